// ----- hw/rtl/tsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tsfc_pkg
// Widths, register indexes, types and saturation helpers shared by the
// saturation filter chain.
// ----------------------------------------------------------------------------
package tsfc_pkg;

   localparam int INTERNAL_WIDTH  = 24;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int ENABLE_WIDTH    = 3;
   localparam int GAIN_WIDTH      = 16;
   localparam int THR_WIDTH       = 23;
   localparam int SLOPE_WIDTH     = 16;
   localparam int ALPHA_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int GAIN_FRAC       = 12;
   localparam int COEF_FRAC       = 16;

   localparam int OPA_WIDTH  = INTERNAL_WIDTH + 2;
   localparam int OPB_WIDTH  = COEF_FRAC + 1;
   localparam int PROD_WIDTH = OPA_WIDTH + OPB_WIDTH;
   localparam int EXT_WIDTH  = INTERNAL_WIDTH + 3;
   localparam int CMP_WIDTH  = (INTERNAL_WIDTH > THR_WIDTH) ? INTERNAL_WIDTH : THR_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STAGE_ENABLES  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRE_GAIN       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRE_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRE_SLOPE      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POST_GAIN      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POST_THRESHOLD = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POST_SLOPE     = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ALPHAS  = 3'd7;

   localparam logic [GAIN_WIDTH-1:0]     GAIN_RESET  = 16'd4096;
   localparam logic [THR_WIDTH-1:0]      THR_RESET   = 23'h7FFFFF;
   localparam logic [SLOPE_WIDTH-1:0]    SLOPE_RESET = 16'hFFFF;

   localparam int HP_EN_BIT  = 1;
   localparam int LP_EN_BIT  = 2;
   localparam int PRE_EN_BIT = 0;

   typedef logic signed [INTERNAL_WIDTH-1:0] int_type;
   typedef logic [INTERNAL_WIDTH-1:0]        mag_type;
   typedef logic signed [SAMPLE_WIDTH-1:0]   sample_type;
   typedef logic signed [EXT_WIDTH-1:0]      ext_type;
   typedef logic signed [OPA_WIDTH-1:0]      opa_type;
   typedef logic signed [OPB_WIDTH-1:0]      opb_type;
   typedef logic signed [PROD_WIDTH-1:0]     prod_type;
   typedef logic [CMP_WIDTH-1:0]             cmp_type;

   typedef struct packed {
      logic [ENABLE_WIDTH-1:0]   stage_enables;
      logic [GAIN_WIDTH-1:0]     pre_gain;
      logic [THR_WIDTH-1:0]      pre_threshold;
      logic [SLOPE_WIDTH-1:0]    pre_slope;
      logic [GAIN_WIDTH-1:0]     post_gain;
      logic [THR_WIDTH-1:0]      post_threshold;
      logic [SLOPE_WIDTH-1:0]    post_slope;
      logic [2*ALPHA_WIDTH-1:0]  filter_alphas;
   } cfg_type;

   typedef struct packed {
      opa_type opa;
      opb_type opb;
   } mul_req_type;

   typedef struct packed {
      int_type value;
      logic    clip;
   } sat_int_type;

   typedef struct packed {
      sample_type value;
      logic       clip;
   } sat_sample_type;

   function automatic sat_int_type sat_int(input ext_type v);
      sat_int_type r;
      logic [EXT_WIDTH-INTERNAL_WIDTH:0] top;
      top = v[EXT_WIDTH-1:INTERNAL_WIDTH-1];
      if ((&top) || !(|top)) begin
         r.value = v[INTERNAL_WIDTH-1:0];
         r.clip  = 1'b0;
      end else if (v[EXT_WIDTH-1]) begin
         r.value = {1'b1, {(INTERNAL_WIDTH-1){1'b0}}};
         r.clip  = 1'b1;
      end else begin
         r.value = {1'b0, {(INTERNAL_WIDTH-1){1'b1}}};
         r.clip  = 1'b1;
      end
      return r;
   endfunction

   function automatic sat_sample_type sat_sample(input int_type v);
      sat_sample_type r;
      logic [INTERNAL_WIDTH-SAMPLE_WIDTH:0] top;
      top = v[INTERNAL_WIDTH-1:SAMPLE_WIDTH-1];
      if ((&top) || !(|top)) begin
         r.value = v[SAMPLE_WIDTH-1:0];
         r.clip  = 1'b0;
      end else if (v[INTERNAL_WIDTH-1]) begin
         r.value = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         r.clip  = 1'b1;
      end else begin
         r.value = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/tsfc_if.sv -----
// ----------------------------------------------------------------------------
// tsfc channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface tsfc_req_if import tsfc_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface tsfc_rsp_if import tsfc_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       clipped;
   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface tsfc_csr_if import tsfc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/tsfc_csr.sv -----
// ----------------------------------------------------------------------------
// tsfc_csr
// Configuration register file, written one register per word.
// ----------------------------------------------------------------------------
module tsfc_csr import tsfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tsfc_csr_if.sink    csr_chan,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_STAGE_ENABLES:  cfg_in.stage_enables  = csr_chan.data[ENABLE_WIDTH-1:0];
            CSR_PRE_GAIN:       cfg_in.pre_gain       = csr_chan.data[GAIN_WIDTH-1:0];
            CSR_PRE_THRESHOLD:  cfg_in.pre_threshold  = csr_chan.data[THR_WIDTH-1:0];
            CSR_PRE_SLOPE:      cfg_in.pre_slope      = csr_chan.data[SLOPE_WIDTH-1:0];
            CSR_POST_GAIN:      cfg_in.post_gain      = csr_chan.data[GAIN_WIDTH-1:0];
            CSR_POST_THRESHOLD: cfg_in.post_threshold = csr_chan.data[THR_WIDTH-1:0];
            CSR_POST_SLOPE:     cfg_in.post_slope     = csr_chan.data[SLOPE_WIDTH-1:0];
            CSR_FILTER_ALPHAS:  cfg_in.filter_alphas  = csr_chan.data[2*ALPHA_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stage_enables  <= '0;
         cfg_ff.pre_gain       <= GAIN_RESET;
         cfg_ff.pre_threshold  <= THR_RESET;
         cfg_ff.pre_slope      <= SLOPE_RESET;
         cfg_ff.post_gain      <= GAIN_RESET;
         cfg_ff.post_threshold <= THR_RESET;
         cfg_ff.post_slope     <= SLOPE_RESET;
         cfg_ff.filter_alphas  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/tsfc_mul.sv -----
// ----------------------------------------------------------------------------
// tsfc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tsfc_mul import tsfc_pkg::*; (
   input  logic        clock,
   input  mul_req_type mul_req,
   output prod_type    prod
);

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = prod_type'(mul_req.opa) * prod_type'(mul_req.opb);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- hw/rtl/tsfc_seq.sv -----
// ----------------------------------------------------------------------------
// tsfc_seq
// Sequencer that walks one word through compressor, filter and output
// stages, issuing every product to the shared multiplier.
// ----------------------------------------------------------------------------
module tsfc_seq import tsfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   tsfc_req_if.sink    req_chan,
   tsfc_rsp_if.source  rsp_chan,
   output mul_req_type mul_req,
   input  prod_type    prod
);

   typedef enum logic [3:0] {
      S_IDLE, S_CG, S_CK, S_CS, S_HP, S_HPW, S_LP, S_LPW, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   int_type    v_ff, v_in;
   logic       clip_ff, clip_in;
   logic       post_ff, post_in;
   logic       neg_ff, neg_in;
   logic       knee_ff, knee_in;
   mag_type    m_ff, m_in;
   int_type    hp_x1_ff, hp_x1_in;
   int_type    hp_y1_ff, hp_y1_in;
   int_type    lp_y1_ff, lp_y1_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_sample_ff, rsp_sample_in;
   logic       rsp_clipped_ff, rsp_clipped_in;

   logic [GAIN_WIDTH-1:0]  gain_sel;
   logic [THR_WIDTH-1:0]   thr_sel;
   logic [SLOPE_WIDTH-1:0] slope_sel;
   mag_type                mag_w;
   logic [EXT_WIDTH-1:0]   m_raw;
   logic [EXT_WIDTH-1:0]   lim_w;
   mag_type                m_w;
   cmp_type                diff_c;
   cmp_type                knee_sum;
   mag_type                res_w;
   mag_type                res_neg;
   ext_type                q_w;
   sat_int_type            sat_w;
   sat_sample_type         out_w;

   assign gain_sel  = post_ff ? cfg.post_gain : cfg.pre_gain;
   assign thr_sel   = post_ff ? cfg.post_threshold : cfg.pre_threshold;
   assign slope_sel = post_ff ? cfg.post_slope : cfg.pre_slope;

   assign mag_w    = v_ff[INTERNAL_WIDTH-1] ? (mag_type'(~v_ff) + 1'b1) : mag_type'(v_ff);
   assign m_raw    = prod[GAIN_FRAC+EXT_WIDTH-1:GAIN_FRAC];
   assign lim_w    = {4'b0001, {(INTERNAL_WIDTH-1){1'b0}}}
                     - {{(EXT_WIDTH-1){1'b0}}, ~neg_ff};
   assign m_w      = (m_raw > lim_w) ? lim_w[INTERNAL_WIDTH-1:0] : m_raw[INTERNAL_WIDTH-1:0];
   assign diff_c   = cmp_type'(m_w) - cmp_type'(thr_sel);
   assign knee_sum = cmp_type'(thr_sel)
                     + cmp_type'(prod[COEF_FRAC+INTERNAL_WIDTH-1:COEF_FRAC]);
   assign res_w    = knee_ff ? knee_sum[INTERNAL_WIDTH-1:0] : m_ff;
   assign res_neg  = ~res_w + 1'b1;
   assign q_w      = $signed(prod[PROD_WIDTH-1:COEF_FRAC]);
   assign out_w    = sat_sample(v_ff);

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.clipped    = rsp_clipped_ff;

   always_comb begin
      state_in       = state_ff;
      v_in           = v_ff;
      clip_in        = clip_ff;
      post_in        = post_ff;
      neg_in         = neg_ff;
      knee_in        = knee_ff;
      m_in           = m_ff;
      hp_x1_in       = hp_x1_ff;
      hp_y1_in       = hp_y1_ff;
      lp_y1_in       = lp_y1_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_clipped_in = rsp_clipped_ff;
      mul_req.opa    = '0;
      mul_req.opb    = '0;
      sat_w          = sat_int(q_w);

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               v_in     = int_type'(req_chan.sample_in);
               clip_in  = 1'b0;
               post_in  = !cfg.stage_enables[PRE_EN_BIT];
               if (cfg.stage_enables[PRE_EN_BIT]) begin
                  state_in = S_CG;
               end else if (cfg.stage_enables[HP_EN_BIT]) begin
                  state_in = S_HP;
               end else if (cfg.stage_enables[LP_EN_BIT]) begin
                  state_in = S_LP;
               end else begin
                  state_in = S_CG;
               end
            end
         end
         S_CG: begin
            neg_in      = v_ff[INTERNAL_WIDTH-1];
            mul_req.opa = opa_type'({2'b00, mag_w});
            mul_req.opb = opb_type'({1'b0, gain_sel});
            state_in    = S_CK;
         end
         S_CK: begin
            m_in        = m_w;
            knee_in     = cmp_type'(m_w) > cmp_type'(thr_sel);
            clip_in     = clip_ff | (m_raw > lim_w);
            mul_req.opa = opa_type'({2'b00, diff_c[INTERNAL_WIDTH-1:0]});
            mul_req.opb = opb_type'({1'b0, slope_sel});
            state_in    = S_CS;
         end
         S_CS: begin
            v_in = neg_ff ? int_type'(res_neg) : int_type'(res_w);
            if (!post_ff) begin
               post_in = 1'b1;
               if (cfg.stage_enables[HP_EN_BIT]) begin
                  state_in = S_HP;
               end else if (cfg.stage_enables[LP_EN_BIT]) begin
                  state_in = S_LP;
               end else begin
                  state_in = S_CG;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_HP: begin
            mul_req.opa = opa_type'(hp_y1_ff) + opa_type'(v_ff) - opa_type'(hp_x1_ff);
            mul_req.opb = opb_type'({1'b0, cfg.filter_alphas[ALPHA_WIDTH-1:0]});
            state_in    = S_HPW;
         end
         S_HPW: begin
            hp_x1_in = v_ff;
            hp_y1_in = sat_w.value;
            v_in     = sat_w.value;
            clip_in  = clip_ff | sat_w.clip;
            state_in = cfg.stage_enables[LP_EN_BIT] ? S_LP : S_CG;
         end
         S_LP: begin
            mul_req.opa = opa_type'(v_ff) - opa_type'(lp_y1_ff);
            mul_req.opb = opb_type'({1'b0, cfg.filter_alphas[2*ALPHA_WIDTH-1:ALPHA_WIDTH]});
            state_in    = S_LPW;
         end
         S_LPW: begin
            sat_w    = sat_int(ext_type'(lp_y1_ff) + q_w);
            lp_y1_in = sat_w.value;
            v_in     = sat_w.value;
            clip_in  = clip_ff | sat_w.clip;
            state_in = S_CG;
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = out_w.value;
               rsp_clipped_in = clip_ff | out_w.clip;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hp_x1_ff     <= '0;
         hp_y1_ff     <= '0;
         lp_y1_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hp_x1_ff     <= hp_x1_in;
         hp_y1_ff     <= hp_y1_in;
         lp_y1_ff     <= lp_y1_in;
      end
      v_ff           <= v_in;
      clip_ff        <= clip_in;
      post_ff        <= post_in;
      neg_ff         <= neg_in;
      knee_ff        <= knee_in;
      m_ff           <= m_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready)
      |=> (state_ff == S_CG || state_ff == S_HP || state_ff == S_LP))
      else $error("accepted word did not start its first stage");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the done step");

   a_mag_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CS) |-> (m_ff <= {1'b1, {(INTERNAL_WIDTH-1){1'b0}}}))
      else $error("compressor magnitude above limit");

   a_hp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_HPW) |=> ($stable(hp_x1_ff) && $stable(hp_y1_ff)))
      else $error("high-pass state changed outside its update step");

   a_lp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LPW) |=> $stable(lp_y1_ff))
      else $error("low-pass state changed outside its update step");
`endif

endmodule

// ----- hw/rtl/tape_saturation_filter_chain.sv -----
// ----------------------------------------------------------------------------
// tape_saturation_filter_chain
// Pre-compressor, one-pole high-pass, one-pole low-pass and post-compressor
// on signed Q1.15 audio, sharing one multiplier under a sequencer.
// ----------------------------------------------------------------------------
// req_chan takes one input word (sample_in); rsp_chan returns one word per
// input (sample_out, clipped). csr_chan writes a register by index and is
// always ready; write it only while no word is in flight.
// The sequencer takes one word at a time: req_chan.ready is high only while
// idle. Every product goes through the single shared multiplier, one per
// step with the product registered. After acceptance a word runs the
// enabled pre-compressor (CG, CK, CS), high-pass (HP, HPW) and low-pass
// (LP, LPW) steps, then the post-compressor and the done step, before the
// next acceptance; the result word and ready return in the same cycle.
// A stalled receiver leaves the result in the output register; the next word
// is still accepted and runs to its done step, where it waits for the
// register to free up.
// Reset clears the registers to their defaults and the filter history to
// zero and drops any pending result.
// ----------------------------------------------------------------------------
module tape_saturation_filter_chain import tsfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tsfc_req_if.sink    req_chan,
   tsfc_rsp_if.source  rsp_chan,
   tsfc_csr_if.sink    csr_chan
);

   cfg_type     cfg;
   mul_req_type mul_req;
   prod_type    prod;

   tsfc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tsfc_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   tsfc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mul_req  (mul_req),
      .prod     (prod)
   );

endmodule

// ----- verif/tape_saturation_filter_chain_tb.sv -----
// ----------------------------------------------------------------------------
// tape_saturation_filter_chain_tb
// Self-checking bench for the saturation filter chain. A driver feeds input
// words from a queue with random gaps, a monitor takes result words under
// random stalls, and a fixed-point predictor of the compressor and filter
// chain checks every result word field by field. Register settings change
// between blocks of words, covering corner values, every stage enable mix
// and random settings.
// ----------------------------------------------------------------------------
module tape_saturation_filter_chain_tb;
   import tsfc_pkg::*;

   localparam int     LIMIT_CYCLES = 1_000_000;
   localparam int     RANDOM_BLOCKS = 16;
   localparam int     WORDS_PER_BLOCK = 110;
   localparam longint INT_MAX = (64'sd1 <<< (INTERNAL_WIDTH - 1)) - 1;
   localparam longint INT_MIN = -INT_MAX - 1;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef struct packed {
      sample_type sample_out;
      logic       clipped;
   } chain_word_t;

   logic clock;
   logic reset;

   tsfc_req_if req_bus ();
   tsfc_rsp_if rsp_bus ();
   tsfc_csr_if csr_bus ();

   tape_saturation_filter_chain i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor state
   cfg_type settings;
   int_type hp_in;
   int_type hp_out;
   int_type lp_out;

   sample_type  pending_samples[$];
   chain_word_t expected_words[$];

   bit req_calm;
   bit rsp_calm;
   int gap_left;
   int stall_left;
   int mismatches;
   int words_sent;
   int words_checked;
   int clipped_seen;
   int blocks_run;
   int cycles;

   sample_type corner_samples[8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                     16'sh0001, 16'sh4000, 16'shC000, 16'sh7FFF};

   function automatic longint clamp_internal(input longint v, inout logic clip);
      if (v > INT_MAX) begin
         clip = 1'b1;
         return INT_MAX;
      end
      if (v < INT_MIN) begin
         clip = 1'b1;
         return INT_MIN;
      end
      return v;
   endfunction

   function automatic longint knee(input longint x, input longint gain, input longint thr,
                                   input longint slope, inout logic clip);
      logic   neg;
      longint mag;
      longint m;
      longint lim;
      neg = (x < 0);
      mag = neg ? -x : x;
      m = (mag * gain) >>> GAIN_FRAC;
      lim = neg ? -INT_MIN : INT_MAX;
      if (m > lim) begin
         m = lim;
         clip = 1'b1;
      end
      if (m > thr)
         m = thr + (((m - thr) * slope) >>> COEF_FRAC);
      return neg ? -m : m;
   endfunction

   function automatic chain_word_t run_chain(input sample_type s);
      chain_word_t r;
      logic        clip;
      longint      v;
      longint      a;
      longint      y;
      clip = 1'b0;
      v = longint'(s);
      if (settings.stage_enables[PRE_EN_BIT])
         v = knee(v, settings.pre_gain, settings.pre_threshold, settings.pre_slope, clip);
      if (settings.stage_enables[HP_EN_BIT]) begin
         a = longint'(settings.filter_alphas[ALPHA_WIDTH-1:0]);
         y = clamp_internal(((longint'(hp_out) + v - longint'(hp_in)) * a) >>> COEF_FRAC,
                            clip);
         hp_in = int_type'(v);
         hp_out = int_type'(y);
         v = y;
      end
      if (settings.stage_enables[LP_EN_BIT]) begin
         a = longint'(settings.filter_alphas[2*ALPHA_WIDTH-1:ALPHA_WIDTH]);
         y = clamp_internal(longint'(lp_out) + (((v - longint'(lp_out)) * a) >>> COEF_FRAC),
                            clip);
         lp_out = int_type'(y);
         v = y;
      end
      v = knee(v, settings.post_gain, settings.post_threshold, settings.post_slope, clip);
      if (v > SAMPLE_MAX) begin
         v = SAMPLE_MAX;
         clip = 1'b1;
      end
      if (v < SAMPLE_MIN) begin
         v = SAMPLE_MIN;
         clip = 1'b1;
      end
      r.sample_out = sample_type'(v);
      r.clipped = clip;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [GAIN_WIDTH-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return GAIN_RESET;
         3: return GAIN_WIDTH'($urandom_range(0, 8192));
         default: return GAIN_WIDTH'($urandom());
      endcase
   endfunction

   function automatic logic [THR_WIDTH-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return THR_RESET;
         2: return THR_WIDTH'($urandom_range(0, 40000));
         3: return THR_WIDTH'($urandom_range(0, 1 << 20));
         default: return THR_WIDTH'($urandom());
      endcase
   endfunction

   function automatic logic [SLOPE_WIDTH-1:0] pick_slope();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return SLOPE_RESET;
         default: return SLOPE_WIDTH'($urandom());
      endcase
   endfunction

   function automatic logic [ALPHA_WIDTH-1:0] pick_alpha();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return ALPHA_WIDTH'($urandom());
      endcase
   endfunction

   function automatic cfg_type random_settings(input int blk);
      cfg_type c;
      c.stage_enables = (blk < 8) ? blk[ENABLE_WIDTH-1:0]
                                  : ENABLE_WIDTH'($urandom_range(0, 7));
      c.pre_gain = pick_gain();
      c.pre_threshold = pick_threshold();
      c.pre_slope = pick_slope();
      c.post_gain = pick_gain();
      c.post_threshold = pick_threshold();
      c.post_slope = pick_slope();
      c.filter_alphas = {pick_alpha(), pick_alpha()};
      return c;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_STAGE_ENABLES:  settings.stage_enables = value[ENABLE_WIDTH-1:0];
         CSR_PRE_GAIN:       settings.pre_gain = value[GAIN_WIDTH-1:0];
         CSR_PRE_THRESHOLD:  settings.pre_threshold = value[THR_WIDTH-1:0];
         CSR_PRE_SLOPE:      settings.pre_slope = value[SLOPE_WIDTH-1:0];
         CSR_POST_GAIN:      settings.post_gain = value[GAIN_WIDTH-1:0];
         CSR_POST_THRESHOLD: settings.post_threshold = value[THR_WIDTH-1:0];
         CSR_POST_SLOPE:     settings.post_slope = value[SLOPE_WIDTH-1:0];
         CSR_FILTER_ALPHAS:  settings.filter_alphas = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c);
      write_register(CSR_FILTER_ALPHAS, CSR_DATA_WIDTH'(c.filter_alphas));
      write_register(CSR_PRE_GAIN, CSR_DATA_WIDTH'(c.pre_gain));
      write_register(CSR_PRE_THRESHOLD, CSR_DATA_WIDTH'(c.pre_threshold));
      write_register(CSR_PRE_SLOPE, CSR_DATA_WIDTH'(c.pre_slope));
      write_register(CSR_POST_GAIN, CSR_DATA_WIDTH'(c.post_gain));
      write_register(CSR_POST_THRESHOLD, CSR_DATA_WIDTH'(c.post_threshold));
      write_register(CSR_POST_SLOPE, CSR_DATA_WIDTH'(c.post_slope));
      write_register(CSR_STAGE_ENABLES, CSR_DATA_WIDTH'(c.stage_enables));
      blocks_run++;
   endtask

   // idle means nothing queued, nothing offered and nothing outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || expected_words.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic feed_corners();
      foreach (corner_samples[i])
         pending_samples.push_back(corner_samples[i]);
      wait_drained();
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // input word driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_words.push_back(run_chain(req_bus.sample_in));
            words_sent++;
            gap_left = req_calm ? 0 : gap_length();
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.sample_in <= pending_samples.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result word monitor
   always @(posedge clock) begin
      chain_word_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_checked++;
            if (rsp_bus.clipped === 1'b1)
               clipped_seen++;
            if (expected_words.size() == 0) begin
               $error("unexpected result word: sample_out %0d clipped %0b",
                      rsp_bus.sample_out, rsp_bus.clipped);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, got %0d", want.sample_out,
                         rsp_bus.sample_out);
                  mismatches++;
               end
               if (rsp_bus.clipped !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, rsp_bus.clipped);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0)
               stall_left = gap_length();
         end
      end
   end

   initial begin
      cfg_type    c;
      sample_type s;
      sample_type prev;
      req_bus.valid = 1'b0;
      req_bus.sample_in = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      settings = '{stage_enables: '0, pre_gain: GAIN_RESET, pre_threshold: THR_RESET,
                   pre_slope: SLOPE_RESET, post_gain: GAIN_RESET,
                   post_threshold: THR_RESET, post_slope: SLOPE_RESET, filter_alphas: '0};
      hp_in = '0;
      hp_out = '0;
      lp_out = '0;
      prev = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // register defaults out of reset
      feed_corners();

      // every stage on, heavy gains, knee at zero slope above range, output clipping
      c.stage_enables = 3'b111;
      c.pre_gain = '1;
      c.pre_threshold = 23'd1000;
      c.pre_slope = 16'h8000;
      c.post_gain = '1;
      c.post_threshold = THR_RESET;
      c.post_slope = '0;
      c.filter_alphas = '1;
      apply_settings(c);
      feed_corners();

      // zero gain must give zero, never a negative zero
      c.stage_enables = 3'b001;
      c.pre_gain = '0;
      c.pre_threshold = '0;
      c.pre_slope = '1;
      c.post_gain = GAIN_RESET;
      c.post_threshold = '0;
      c.post_slope = '1;
      c.filter_alphas = '0;
      apply_settings(c);
      feed_corners();

      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         apply_settings(random_settings(b));
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
            case ($urandom_range(0, 9))
               0: s = 16'sh7FFF;
               1: s = 16'sh8000;
               2: s = sample_type'(int'($urandom_range(0, 64)) - 32);
               3: s = prev;
               default: s = sample_type'($urandom());
            endcase
            prev = s;
            pending_samples.push_back(s);
         end
         wait_drained();
      end

      $display("ran %0d input words under %0d register settings", words_sent, blocks_run);
      $display("checked %0d result words, %0d of them clipped", words_checked, clipped_seen);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- tape_saturation_filter_chain.f -----
hw/rtl/tsfc_pkg.sv
hw/rtl/tsfc_if.sv
hw/rtl/tsfc_csr.sv
hw/rtl/tsfc_mul.sv
hw/rtl/tsfc_seq.sv
hw/rtl/tape_saturation_filter_chain.sv
verif/tape_saturation_filter_chain_tb.sv
